// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the heap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define MHBE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define MHBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mhbe_pkg.sv -----
// Shared types and codes for the max-heap build and extract block.
`timescale 1ns / 1ps
`default_nettype none

package mhbe_pkg;

  // Operation codes carried with each input beat.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_BUILD   = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 9;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  // One finished result as handed from the controller to the output stage.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [COUNT_W-1:0]      count;
    status_t                 status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/mhbe_store.sv -----
// Key store: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mhbe_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [AW-1:0]                       waddr,
  input  wire logic signed [mhbe_pkg::KEY_W-1:0]   wdata,
  input  wire logic [AW-1:0]                       raddr0,
  input  wire logic [AW-1:0]                       raddr1,
  output logic signed [mhbe_pkg::KEY_W-1:0]        rdata0,
  output logic signed [mhbe_pkg::KEY_W-1:0]        rdata1
);
  import mhbe_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ----- rtl/mhbe_ctrl.sv -----
// Sequencer for load, bottom-up build and extract with sift-down over the store.
`timescale 1ns / 1ps
`default_nettype none

module mhbe_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_op,
  input  wire logic signed [mhbe_pkg::KEY_W-1:0]  in_key,
  input  wire logic                               out_free,
  output logic                                    done,
  output mhbe_pkg::res_t                          res,
  output logic                                    we,
  output logic [AW-1:0]                           waddr,
  output logic signed [mhbe_pkg::KEY_W-1:0]       wdata,
  output logic [AW-1:0]                           raddr0,
  output logic [AW-1:0]                           raddr1,
  input  wire logic signed [mhbe_pkg::KEY_W-1:0]  rdata0,
  input  wire logic signed [mhbe_pkg::KEY_W-1:0]  rdata1
);
  import mhbe_pkg::*;

  localparam int PW = CW + 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_BLD_RD   = 7'b0000010,
    S_BLD_LD   = 7'b0000100,
    S_EXT_LD   = 7'b0001000,
    S_SIFT_RD  = 7'b0010000,
    S_SIFT_CMP = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           count;
  logic [CW-1:0]           heap_n;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           bidx;
  logic                    building;
  logic signed [KEY_W-1:0] cur;
  logic signed [KEY_W-1:0] res_key;
  status_t                 res_status;

  logic                    accept;
  logic                    full;
  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           pos_m1;
  logic [CW-1:0]           bidx_m1;
  logic [PW-1:0]           lft;
  logic [PW-1:0]           rgt;
  logic [PW-1:0]           lft_m1;
  logic [PW-1:0]           n_ext;
  logic                    rgt_ok;
  logic                    lft_ok;
  logic signed [KEY_W-1:0] pick;
  logic [CW+COUNT_W-1:0]   count_ext;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(CAPACITY));
  assign cnt_m1   = count - CW'(1);
  assign pos_m1   = pos - CW'(1);
  assign bidx_m1  = bidx - CW'(1);
  assign lft      = {pos, 1'b0};
  assign rgt      = {pos, 1'b1};
  assign lft_m1   = lft - PW'(1);
  assign n_ext    = {1'b0, heap_n};

  // Child selection: the right child is tried first, the left wins only when strictly larger.
  assign rgt_ok = (rgt <= n_ext) && (rdata1 > cur);
  assign pick   = rgt_ok ? rdata1 : cur;
  assign lft_ok = (lft <= n_ext) && (rdata0 > pick);

  // Store addressing and write-back.
  always_comb begin
    raddr0 = lft_m1[AW-1:0];
    raddr1 = lft[AW-1:0];
    we     = 1'b0;
    waddr  = pos_m1[AW-1:0];
    wdata  = cur;
    case (state)
      S_IDLE: begin
        raddr0 = '0;
        raddr1 = cnt_m1[AW-1:0];
        if (accept && (in_op == OP_LOAD) && !full) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = in_key;
        end
      end
      S_BLD_RD: begin
        raddr0 = bidx_m1[AW-1:0];
      end
      S_SIFT_CMP: begin
        we = 1'b1;
        if (lft_ok) begin
          wdata = rdata0;
        end else if (rgt_ok) begin
          wdata = rdata1;
        end else begin
          wdata = cur;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((in_op == OP_BUILD) && (count > CW'(1))) begin
            state_next = S_BLD_RD;
          end else if ((in_op == OP_EXTRACT) && (count != '0)) begin
            state_next = S_EXT_LD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_BLD_RD:   state_next = S_BLD_LD;
      S_BLD_LD:   state_next = S_SIFT_RD;
      S_EXT_LD:   state_next = S_SIFT_RD;
      S_SIFT_RD:  state_next = S_SIFT_CMP;
      S_SIFT_CMP: begin
        if (lft_ok || rgt_ok) begin
          state_next = S_SIFT_RD;
        end else if (building && (bidx != CW'(1))) begin
          state_next = S_BLD_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && (in_op == OP_LOAD) && !full) begin
        count <= count + CW'(1);
      end
      if (state == S_EXT_LD) begin
        count <= cnt_m1;
      end
    end
  end

  // Working registers of the sift and the pending result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          building   <= (in_op == OP_BUILD);
          heap_n     <= count;
          bidx       <= count >> 1;
          res_key    <= '0;
          if ((in_op == OP_LOAD) && full) begin
            res_status <= STS_FULL;
          end else if ((in_op == OP_EXTRACT) && (count == '0)) begin
            res_status <= STS_EMPTY;
          end else begin
            res_status <= STS_OK;
          end
        end
      end
      S_BLD_LD: begin
        cur <= rdata0;
        pos <= bidx;
      end
      S_EXT_LD: begin
        res_key <= rdata0;
        cur     <= rdata1;
        heap_n  <= cnt_m1;
        pos     <= CW'(1);
      end
      S_SIFT_CMP: begin
        if (lft_ok) begin
          pos <= lft[CW-1:0];
        end else if (rgt_ok) begin
          pos <= rgt[CW-1:0];
        end else if (building) begin
          bidx <= bidx_m1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result handed to the output stage.
  assign count_ext  = {{COUNT_W{1'b0}}, count};
  assign done       = (state == S_FINISH) && out_free;
  assign res.key    = res_key;
  assign res.count  = count_ext[COUNT_W-1:0];
  assign res.status = res_status;

endmodule

`default_nettype wire

// ----- rtl/max_heap_build_extract.sv -----
// Top level of the binary max-heap: stream ports, output register, store and sequencer.
// Load writes the key as the beat is accepted. Extract takes the root, moves the last
// entry to it and sifts it down; each level is one store read and one compare.
// Build sifts down each parent from the last to the root; no beat is accepted meanwhile.
// One item is worked on at a time; a finished result waits in the output register.
// Reset clears the key count and control state; the store content is kept.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_build_extract #(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] key_in
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] key_out, [40:32] count_out, [47:41] zero
  output logic [1:0]       m_tuser    // [1:0] status
);
  import mhbe_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [KEY_W-1:0] wdata;
  logic [AW-1:0]           raddr0;
  logic [AW-1:0]           raddr1;
  logic signed [KEY_W-1:0] rdata0;
  logic signed [KEY_W-1:0] rdata1;
  logic                    out_free;
  logic                    done;
  res_t                    res;

  mhbe_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  mhbe_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_key   (s_tdata),
    .out_free (out_free),
    .done     (done),
    .res      (res),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .rdata0   (rdata0),
    .rdata1   (rdata1)
  );

  assign out_free = !m_tvalid || m_tready;

  // Output register: loaded when a result is done, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {7'b0, res.count, res.key};
      m_tuser <= res.status;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mhbe_checker.sv -----
// Port-level checks for the max-heap block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mhbe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import mhbe_pkg::*;

  // Reset leaves no result pending.
  `MHBE_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result pending after reset")

  // A stalled result beat holds its payload.
  `MHBE_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // One item at a time: an accepted beat drops ready for the next cycle.
  `MHBE_ASSERT(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

  // An extract on an empty heap gives a zero key and a zero count.
  `MHBE_ASSERT(a_empty_zero, clk, rst, m_tvalid && (m_tuser == STS_EMPTY) |-> (m_tdata[40:0] == 41'd0), "empty extract not zero")

endmodule

bind max_heap_build_extract mhbe_checker u_mhbe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/max_heap_build_extract_tb.sv -----
// Self-checking testbench for the max-heap build and extract block.
`timescale 1ns / 1ps

module max_heap_build_extract_tb;
  import mhbe_pkg::*;

  localparam int HEAP_CAPACITY = 256;
  // The opcode left unused by the block: a no-op that still answers.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    bit                      drain;
  } heap_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key_in
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [31:0] key_out, [40:32] count_out, [47:41] zero
  logic [1:0]  m_tuser;        // [1:0] status

  // Beats still to be sent and results still owed by the block.
  heap_item_t op_backlog[$];
  res_t       heap_replies[$];
  heap_item_t cur_item;

  // Own copy of the heap store and key count.
  logic signed [KEY_W-1:0] heap_keys [1:HEAP_CAPACITY];
  int heap_count = 0;

  int plan_count = 0;
  int fails = 0;
  int result_idx = 0;
  int hold_off = 0;
  int drv_quiet = 0;
  int stall_left = 0;
  int mon_quiet = 0;

  max_heap_build_extract #(
    .CAPACITY(HEAP_CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long, with quiet runs of no idling.
  task automatic draw_gap(inout int quiet, output int gap);
    int r;
    r = $urandom_range(0, 99);
    gap = 0;
    if (quiet > 0) begin
      quiet--;
    end else if (r < 3) begin
      quiet = $urandom_range(20, 80);
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fails < MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0h, want %0h", result_idx, what, got, want);
    fails++;
  endtask

  // Sift the key at start down within the first n entries; the right child is tried first.
  task automatic sift_down(input int start, input int n);
    int pos;
    int left;
    int right;
    int best;
    bit done;
    logic signed [KEY_W-1:0] t;
    pos = start;
    done = 1'b0;
    while (!done && pos >= 1 && pos <= n) begin
      left = 2 * pos;
      right = left + 1;
      best = pos;
      if (right <= n && heap_keys[right] > heap_keys[best]) best = right;
      if (left <= n && heap_keys[left] > heap_keys[best]) best = left;
      if (best == pos) begin
        done = 1'b1;
      end else begin
        t = heap_keys[pos];
        heap_keys[pos] = heap_keys[best];
        heap_keys[best] = t;
        pos = best;
      end
    end
  endtask

  // Apply one accepted beat to the heap copy and queue the result it must give.
  task automatic heap_apply(input heap_item_t it);
    res_t r;
    int i;
    r.key = '0;
    r.status = STS_OK;
    case (it.op)
      OP_LOAD: begin
        if (heap_count >= HEAP_CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          heap_count++;
          heap_keys[heap_count] = it.key;
        end
      end
      OP_BUILD: begin
        for (i = heap_count / 2; i >= 1; i--) sift_down(i, heap_count);
      end
      OP_EXTRACT: begin
        if (heap_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.key = heap_keys[1];
          heap_keys[1] = heap_keys[heap_count];
          heap_count--;
          sift_down(1, heap_count);
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(heap_count);
    heap_replies.push_back(r);
  endtask

  task automatic queue_op(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                          input bit drain);
    heap_item_t it;
    it.op = op;
    it.key = key;
    it.drain = drain;
    op_backlog.push_back(it);
    if (op == OP_LOAD && plan_count < HEAP_CAPACITY) plan_count++;
    if (op == OP_EXTRACT && plan_count > 0) plan_count--;
  endtask

  // Keys: full range, a narrow band full of ties, or the extremes.
  function automatic logic signed [KEY_W-1:0] draw_key(input int style);
    logic signed [KEY_W-1:0] k;
    case (style)
      0: k = $urandom;
      1: k = $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 5))
          0: k = 32'h8000_0000;
          1: k = 32'h8000_0001;
          2: k = 32'h7fff_ffff;
          3: k = 32'h7fff_fffe;
          4: k = 32'hffff_ffff;
          default: k = 32'h0000_0000;
        endcase
      end
    endcase
    return k;
  endfunction

  // Driver: a beat is held until taken; the next one follows an idle gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        heap_apply(cur_item);
        draw_gap(drv_quiet, hold_off);
      end
      if (s_tvalid && !s_tready) begin
        // Beat still waiting to be taken.
      end else if (hold_off > 0) begin
        hold_off--;
        s_tvalid <= 1'b0;
      end else if (op_backlog.size() != 0 &&
                   !(op_backlog[0].drain && heap_replies.size() != 0)) begin
        cur_item = op_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_item.key;
        s_tuser  <= cur_item.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest owed result.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (heap_replies.size() == 0) begin
          report_mismatch("result with none owed", {m_tuser, m_tdata}, 64'h0);
        end else begin
          want = heap_replies.pop_front();
          if (m_tdata[31:0] !== want.key)
            report_mismatch("key_out", m_tdata[31:0], want.key);
          if (m_tdata[40:32] !== want.count)
            report_mismatch("count_out", m_tdata[40:32], want.count);
          if (m_tuser !== want.status)
            report_mismatch("status", m_tuser, want.status);
        end
        result_idx++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        draw_gap(mon_quiet, stall_left);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int n;
    int m;
    int style;
    int i;

    // Directed: empty cases, the spare opcode, extremes, ties, extract before
    // build and load after build.
    queue_op(OP_EXTRACT, 32'h0, 1'b0);
    queue_op(OP_BUILD, 32'h0, 1'b0);
    queue_op(OP_NONE, 32'hffff_ffff, 1'b0);
    queue_op(OP_LOAD, 32'h8000_0000, 1'b0);
    queue_op(OP_BUILD, 32'h0, 1'b0);
    queue_op(OP_EXTRACT, 32'h0, 1'b0);
    queue_op(OP_LOAD, 32'hffff_ffff, 1'b0);
    queue_op(OP_LOAD, 32'h7fff_ffff, 1'b0);
    queue_op(OP_LOAD, 32'h0000_0000, 1'b0);
    queue_op(OP_LOAD, 32'h8000_0000, 1'b0);
    queue_op(OP_LOAD, 32'h0000_0005, 1'b0);
    queue_op(OP_LOAD, 32'h0000_0005, 1'b0);
    queue_op(OP_EXTRACT, 32'h0, 1'b0);
    queue_op(OP_BUILD, 32'h0, 1'b0);
    queue_op(OP_LOAD, 32'h7fff_fffe, 1'b0);
    queue_op(OP_NONE, 32'h0, 1'b0);
    queue_op(OP_EXTRACT, 32'h0, 1'b0);
    queue_op(OP_EXTRACT, 32'h0, 1'b0);
    queue_op(OP_EXTRACT, 32'h0, 1'b0);

    // Fill the store to the top and push past it, then build and take a few.
    // The first of these waits until the block has answered everything.
    queue_op(OP_LOAD, draw_key(0), 1'b1);
    while (plan_count < HEAP_CAPACITY) queue_op(OP_LOAD, draw_key($urandom_range(0, 2)), 1'b0);
    queue_op(OP_LOAD, draw_key(0), 1'b0);
    queue_op(OP_LOAD, draw_key(0), 1'b0);
    queue_op(OP_BUILD, 32'h0, 1'b0);
    for (i = 0; i < 8; i++) queue_op(OP_EXTRACT, 32'h0, 1'b0);

    // Mostly load-build-extract runs with random content, the rest noise.
    while (op_backlog.size() < 1020) begin
      if ($urandom_range(0, 9) < 7) begin
        style = $urandom_range(0, 2);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
        for (i = 0; i < n; i++)
          queue_op(OP_LOAD, draw_key(style), ($urandom_range(0, 39) == 0));
        queue_op(OP_BUILD, draw_key(0), 1'b0);
        m = ($urandom_range(0, 7) == 0) ? plan_count + 1 : $urandom_range(1, 12);
        for (i = 0; i < m; i++)
          queue_op(OP_EXTRACT, draw_key(0), ($urandom_range(0, 39) == 0));
      end else begin
        queue_op(2'($urandom_range(0, 3)), draw_key($urandom_range(0, 2)),
                 ($urandom_range(0, 39) == 0));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Sampled between edges, once the driver's and the monitor's updates have settled.
    while (op_backlog.size() != 0 || s_tvalid || heap_replies.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (heap_replies.size() != 0) report_mismatch("results never delivered",
                                                  heap_replies.size(), 0);

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("timeout with %0d results owed", heap_replies.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
